// File: hw/rtl/elg_pkg.sv
// shared types and codes for the elgamal unit
`default_nettype none
package elg_pkg;
  localparam logic [1:0] KIND_PUBKEY  = 2'd0;
  localparam logic [1:0] KIND_ENCRYPT = 2'd1;
  localparam logic [1:0] KIND_DECRYPT = 2'd2;
  localparam logic [1:0] REG_MODULUS   = 2'd0;
  localparam logic [1:0] REG_GENERATOR = 2'd1;
  localparam logic [1:0] REG_KEY       = 2'd2;
  // datapath operand selects
  localparam logic [2:0] SEL_ONE  = 3'd0;
  localparam logic [2:0] SEL_GEN  = 3'd1;
  localparam logic [2:0] SEL_PK   = 3'd2;
  localparam logic [2:0] SEL_C1   = 3'd3;
  localparam logic [2:0] SEL_S    = 3'd4;
  localparam logic [2:0] SEL_MSG  = 3'd5;
  localparam logic [2:0] SEL_C2   = 3'd6;
  localparam logic [2:0] SEL_ACC  = 3'd7;
  // exponent selects
  localparam logic [1:0] EXP_KEY   = 2'd0;
  localparam logic [1:0] EXP_NONCE = 2'd1;
  localparam logic [1:0] EXP_PM2   = 2'd2;
  // result destinations
  localparam logic [2:0] DST_PK   = 3'd0;
  localparam logic [2:0] DST_E1   = 3'd1;
  localparam logic [2:0] DST_T    = 3'd2;
  localparam logic [2:0] DST_E2   = 3'd3;
  localparam logic [2:0] DST_S    = 3'd4;
  localparam logic [2:0] DST_PT   = 3'd5;
  typedef struct packed {
    logic       clear;     // zero all results, latch inputs
    logic       exp_start; // start exponentiation
    logic       mul_start; // start single multiply acc*base
    logic [2:0] base_sel;
    logic [1:0] exp_sel;
    logic [2:0] dst;
  } elg_cmd_t;
  typedef struct packed {
    logic busy;
    logic p_zero;
  } elg_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/elgamal_encrypt_decrypt.sv
// top level of the elgamal modular exponentiation unit
`default_nettype none
// One request at a time; its fields are latched in the accepting cycle. A request
// takes up to three exponentiations and one single product on one shift-add
// modular multiplier. Every operation first reduces its operand mod p, msb first;
// a modular multiply adds and doubles once per bit of its multiplier operand,
// and an exponentiation does a multiply and a square for each exponent bit. A
// public key request does one exponentiation; a zero modulus answers at once.
// The result is held until taken; the next request is accepted the cycle after.
module elgamal_encrypt_decrypt #(
  parameter int WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [WIDTH-1:0]             cfg_data,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // message, nonce, cipher_first, cipher_second
  input  wire logic [4*WIDTH-1:0]           s_tdata,
  // kind
  input  wire logic [1:0]                   s_tuser,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // public_key, enc_first, enc_second, plaintext
  output logic [4*WIDTH-1:0]                m_tdata
);
  import elg_pkg::*;
  logic [WIDTH-1:0] modulus, generator, private_key;
  logic [WIDTH-1:0] pk, e1, e2, pt;
  elg_cmd_t cmd;
  elg_sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(2); generator <= '0; private_key <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS:   modulus <= cfg_data;
        REG_GENERATOR: generator <= cfg_data;
        REG_KEY:       private_key <= cfg_data;
        default: ;
      endcase
    end
  end

  elg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_kind(s_tuser),
    .in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
    .cmd(cmd), .sts(sts)
  );

  elg_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .modulus(modulus), .generator(generator), .private_key(private_key),
    .message(s_tdata[WIDTH-1:0]), .nonce(s_tdata[2*WIDTH-1:WIDTH]),
    .cipher_first(s_tdata[3*WIDTH-1:2*WIDTH]),
    .cipher_second(s_tdata[4*WIDTH-1:3*WIDTH]),
    .public_key(pk), .enc_first(e1), .enc_second(e2), .plaintext(pt)
  );

  assign m_tdata = {pt, e2, e1, pk};
endmodule
`default_nettype wire

// File: hw/rtl/elg_datapath.sv
// modular arithmetic datapath: reduction, shift-add multiply, exponentiation
`default_nettype none
module elg_datapath #(
  parameter int WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire elg_pkg::elg_cmd_t   cmd,
  output elg_pkg::elg_sts_t        sts,
  input  wire logic [WIDTH-1:0]    modulus,
  input  wire logic [WIDTH-1:0]    generator,
  input  wire logic [WIDTH-1:0]    private_key,
  input  wire logic [WIDTH-1:0]    message,
  input  wire logic [WIDTH-1:0]    nonce,
  input  wire logic [WIDTH-1:0]    cipher_first,
  input  wire logic [WIDTH-1:0]    cipher_second,
  output logic [WIDTH-1:0]         public_key,
  output logic [WIDTH-1:0]         enc_first,
  output logic [WIDTH-1:0]         enc_second,
  output logic [WIDTH-1:0]         plaintext
);
  import elg_pkg::*;
  localparam int CW = $clog2(WIDTH + 1);
  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_RED  = 3'd1;
  localparam logic [2:0] M_LOAD = 3'd2;
  localparam logic [2:0] M_EXP  = 3'd3;
  localparam logic [2:0] M_MUL  = 3'd4;
  localparam logic [2:0] M_SQR  = 3'd5;

  logic [2:0]       mode;
  logic [WIDTH-1:0] msg_r, non_r, c1_r, c2_r;
  logic [WIDTH-1:0] tmp, s_r;
  logic [WIDTH-1:0] acc, base, ex, mb, ma, macc;
  logic [WIDTH:0]   rem, rem_sh;
  logic [CW-1:0]    cnt;
  logic             is_exp;
  logic [2:0]       dst;
  logic [WIDTH-1:0] opnd, exp_val, pm2, res, one_mod;
  logic             fin;

  // (a+b) mod p, a,b < p
  function automatic logic [WIDTH-1:0] addm(input logic [WIDTH-1:0] a,
                                            input logic [WIDTH-1:0] b,
                                            input logic [WIDTH-1:0] p);
    logic [WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[WIDTH-1:0];
  endfunction

  assign one_mod = (modulus == {{(WIDTH-1){1'b0}}, 1'b1}) ? '0
                   : {{(WIDTH-1){1'b0}}, 1'b1};
  assign pm2 = (modulus >= WIDTH'(2)) ? modulus - WIDTH'(2) : '0;
  assign rem_sh = {rem[WIDTH-1:0], base[WIDTH-1]};

  always_comb begin
    case (cmd.base_sel)
      SEL_GEN: opnd = generator;
      SEL_PK:  opnd = public_key;
      SEL_C1:  opnd = c1_r;
      SEL_S:   opnd = s_r;
      SEL_MSG: opnd = msg_r;
      SEL_C2:  opnd = c2_r;
      SEL_ACC: opnd = tmp;
      default: opnd = '0;
    endcase
    case (cmd.exp_sel)
      EXP_KEY:   exp_val = private_key;
      EXP_NONCE: exp_val = non_r;
      EXP_PM2:   exp_val = pm2;
      default:   exp_val = '0;
    endcase
  end

  // operation finished: exponent used up, or single product complete
  assign fin = (mode == M_EXP && ex == '0) || (mode == M_MUL && !is_exp && mb == '0);
  assign res = (mode == M_EXP) ? acc : macc;

  assign sts = '{busy: (mode != M_IDLE), p_zero: (modulus == '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
    end else begin
      case (mode)
        M_IDLE: begin
          if (cmd.clear) begin
            msg_r <= message; non_r <= nonce;
            c1_r <= cipher_first; c2_r <= cipher_second;
            public_key <= '0; enc_first <= '0; enc_second <= '0; plaintext <= '0;
          end
          if (cmd.exp_start || cmd.mul_start) begin
            // every start first reduces the operand mod p, msb first
            rem    <= '0;
            base   <= opnd;
            cnt    <= CW'(WIDTH);
            dst    <= cmd.dst;
            ex     <= exp_val;
            is_exp <= cmd.exp_start;
            acc    <= cmd.exp_start ? one_mod : tmp;
            mode   <= M_RED;
          end
        end
        M_RED: begin
          // shift in one bit of base, conditionally subtract p
          if (rem_sh >= {1'b0, modulus})
            rem <= rem_sh - {1'b0, modulus};
          else
            rem <= rem_sh;
          base <= {base[WIDTH-2:0], 1'b0};
          cnt  <= cnt - CW'(1);
          if (cnt == CW'(1)) mode <= M_LOAD;
        end
        M_LOAD: begin
          base <= rem[WIDTH-1:0];
          ma   <= rem[WIDTH-1:0];
          mb   <= acc;
          macc <= '0;
          mode <= is_exp ? M_EXP : M_MUL;
        end
        M_EXP: begin
          if (ex == '0) begin
            mode <= M_IDLE;
          end else begin
            // multiply acc by base when the exponent bit is set
            ma   <= base;
            mb   <= ex[0] ? acc : '0;
            macc <= '0;
            mode <= M_MUL;
          end
        end
        M_MUL: begin
          if (mb == '0) begin
            if (is_exp) begin
              if (ex[0]) acc <= macc;
              ma <= base; mb <= base; macc <= '0;
              mode <= M_SQR;
            end else begin
              mode <= M_IDLE;
            end
          end else begin
            if (mb[0]) macc <= addm(macc, ma, modulus);
            ma <= addm(ma, ma, modulus);
            mb <= mb >> 1;
          end
        end
        M_SQR: begin
          if (mb == '0) begin
            base <= macc;
            ex   <= ex >> 1;
            mode <= M_EXP;
          end else begin
            if (mb[0]) macc <= addm(macc, ma, modulus);
            ma <= addm(ma, ma, modulus);
            mb <= mb >> 1;
          end
        end
        default: mode <= M_IDLE;
      endcase
      if (fin) begin
        case (dst)
          DST_PK:  public_key <= res;
          DST_E1:  enc_first <= res;
          DST_E2:  enc_second <= res;
          DST_S:   s_r <= res;
          DST_PT:  plaintext <= res;
          default: tmp <= res;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/elg_ctrl.sv
// sequencer for key, encrypt and decrypt operations
`default_nettype none
module elg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_kind,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output elg_pkg::elg_cmd_t      cmd,
  input  wire elg_pkg::elg_sts_t sts
);
  import elg_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PK   = 4'd1;
  localparam logic [3:0] S_E1   = 4'd2;
  localparam logic [3:0] S_T    = 4'd3;
  localparam logic [3:0] S_E2   = 4'd4;
  localparam logic [3:0] S_S    = 4'd5;
  localparam logic [3:0] S_INV  = 4'd6;
  localparam logic [3:0] S_PT   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state;
  logic [1:0] kind;
  logic       issued;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    if (!sts.busy && !issued) begin
      case (state)
        S_IDLE: cmd.clear = in_valid;
        S_PK:  begin cmd.exp_start = 1'b1; cmd.base_sel = SEL_GEN;
                 cmd.exp_sel = EXP_KEY; cmd.dst = DST_PK; end
        S_E1:  begin cmd.exp_start = 1'b1; cmd.base_sel = SEL_GEN;
                 cmd.exp_sel = EXP_NONCE; cmd.dst = DST_E1; end
        S_T:   begin cmd.exp_start = 1'b1; cmd.base_sel = SEL_PK;
                 cmd.exp_sel = EXP_NONCE; cmd.dst = DST_T; end
        S_E2:  begin cmd.mul_start = 1'b1; cmd.base_sel = SEL_MSG; cmd.dst = DST_E2; end
        S_S:   begin cmd.exp_start = 1'b1; cmd.base_sel = SEL_C1;
                 cmd.exp_sel = EXP_KEY; cmd.dst = DST_S; end
        S_INV: begin cmd.exp_start = 1'b1; cmd.base_sel = SEL_S;
                 cmd.exp_sel = EXP_PM2; cmd.dst = DST_T; end
        S_PT:  begin cmd.mul_start = 1'b1; cmd.base_sel = SEL_C2; cmd.dst = DST_PT; end
        default: cmd = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; issued <= 1'b0; kind <= KIND_PUBKEY;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          kind <= in_kind;
          state <= sts.p_zero ? S_OUT : S_PK;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: begin
          if (!sts.busy) begin
            if (!issued) begin
              issued <= 1'b1;
            end else begin
              issued <= 1'b0;
              case (state)
                S_PK:  state <= (kind == KIND_ENCRYPT) ? S_E1
                              : (kind == KIND_DECRYPT) ? S_S : S_OUT;
                S_E1:  state <= S_T;
                S_T:   state <= S_E2;
                S_S:   state <= S_INV;
                S_INV: state <= S_PT;
                default: state <= S_OUT;
              endcase
            end
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/elg_checker.sv
// port-level checks for the elgamal unit
`default_nettype none
module elg_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken with result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("accepted twice");
endmodule
bind elgamal_encrypt_decrypt elg_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready));
`default_nettype wire
